[sv/xcm_pkg.sv]
package xcm_pkg;

	localparam int MAX_CRIB = 16;
	localparam int OFFSET_BITS = 32;

	localparam int BYTE_W = 8;
	localparam int OFFSET_OUT_W = 32;
	localparam int LEN_CFG_W = 5;
	localparam int CFG_W = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CRIB_BYTES = 16;

	// fill count and effective length hold 0..MAX_CRIB
	localparam int CNT_W = $clog2(MAX_CRIB + 1);
	// cell index into the row
	localparam int IDX_W = $clog2(MAX_CRIB);
	// cell index plus length, wide enough to also index the crib bytes
	localparam int SUM_W = (CNT_W + 1 > 5) ? CNT_W + 1 : 5;

	localparam logic [CFG_IDX_W-1:0] REG_CRIB_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRIB_LOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CRIB_HIGH = 2'd2;

	localparam logic [LEN_CFG_W-1:0] LEN_RESET = 5'd2;

	typedef struct packed {
		logic advance;
		logic clear;
	} cell_ctl_t;

	function automatic logic [CNT_W-1:0] eff_length(input logic [LEN_CFG_W-1:0] cfg);
		logic [7:0] n;
		n = 8'(cfg);
		if (n < 8'd2)
			n = 8'd2;
		if (n > 8'(MAX_CRIB))
			n = 8'(MAX_CRIB);
		return CNT_W'(n);
	endfunction

	function automatic logic [BYTE_W-1:0] crib_byte(input logic [CFG_W-1:0] lo,
			input logic [CFG_W-1:0] hi, input logic [SUM_W-1:0] k);
		logic [2*CFG_W-1:0] all;
		all = {hi, lo};
		if (k < SUM_W'(CRIB_BYTES))
			return all[k[3:0]*BYTE_W +: BYTE_W];
		return '0;
	endfunction

endpackage

[sv/xcm_ifs.sv]
interface xcm_cipher_if;
	logic valid;
	logic ready;
	logic [xcm_pkg::BYTE_W-1:0] cipher_byte;
	logic stream_end;

	modport source (output valid, output cipher_byte, output stream_end, input ready);
	modport sink (input valid, input cipher_byte, input stream_end, output ready);
endinterface

interface xcm_match_if;
	logic valid;
	logic ready;
	logic [xcm_pkg::OFFSET_OUT_W-1:0] match_offset;
	logic [xcm_pkg::BYTE_W-1:0] found_key;
	logic offset_saturated;

	modport source (output valid, output match_offset, output found_key,
		output offset_saturated, input ready);
	modport sink (input valid, input match_offset, input found_key,
		input offset_saturated, output ready);
endinterface

[sv/xor_crib_match_scanner.sv]
// Single-byte XOR crib scanner. Ciphertext beats enter on cipher; each beat
// shifts one byte into a row of MAX_CRIB cells, each cell XORs its byte with
// the aligned crib byte and compares against its right neighbor, so a full
// window of crib_length bytes is checked in the cycle the byte arrives. A match
// is registered and shown on match the next cycle with the window's start
// offset and the key. One byte is taken every cycle as long as the match side
// keeps taking results; a held result stalls input for as long as it waits.
// A beat with stream_end set is checked, then the window, fill count and
// position counter restart. Configuration is written through wr_en, reg_index
// and wr_data, by the user only while no beat is in flight; not enforced here.
module xor_crib_match_scanner (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [xcm_pkg::CFG_IDX_W-1:0]   reg_index,
	input  logic [xcm_pkg::CFG_W-1:0]       wr_data,
	xcm_cipher_if.sink                      cipher,
	xcm_match_if.source                     match
);

	localparam int N = xcm_pkg::MAX_CRIB;
	localparam int BW = xcm_pkg::BYTE_W;

	logic [xcm_pkg::LEN_CFG_W-1:0] crib_length_q;
	logic [xcm_pkg::CFG_W-1:0] crib_low_q;
	logic [xcm_pkg::CFG_W-1:0] crib_high_q;

	logic [xcm_pkg::CNT_W-1:0] fill_q;
	logic [xcm_pkg::OFFSET_BITS-1:0] pos_q;

	logic out_valid_q;
	logic [xcm_pkg::OFFSET_OUT_W-1:0] offset_q;
	logic [BW-1:0] key_q;
	logic sat_q;

	logic accept;
	logic [xcm_pkg::CNT_W-1:0] len;
	logic [xcm_pkg::CNT_W-1:0] fill_next;
	logic [xcm_pkg::CNT_W-1:0] base;
	logic sat;
	logic hit;
	logic [xcm_pkg::OFFSET_BITS-1:0] start;
	xcm_pkg::cell_ctl_t ctl;

	logic [BW-1:0] dout [N];
	logic [BW-1:0] xv [N];
	logic [N-1:0] agree;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crib_length_q <= xcm_pkg::LEN_RESET;
			crib_low_q <= '0;
			crib_high_q <= '0;
		end else if (wr_en) begin
			unique case (reg_index)
				xcm_pkg::REG_CRIB_LENGTH: crib_length_q <= wr_data[xcm_pkg::LEN_CFG_W-1:0];
				xcm_pkg::REG_CRIB_LOW: crib_low_q <= wr_data;
				xcm_pkg::REG_CRIB_HIGH: crib_high_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign cipher.ready = !out_valid_q || match.ready;
	assign accept = cipher.valid && cipher.ready;
	assign ctl.advance = accept;
	assign ctl.clear = cipher.stream_end;

	assign len = xcm_pkg::eff_length(crib_length_q);
	assign base = xcm_pkg::CNT_W'(N) - len;
	assign fill_next = (fill_q < xcm_pkg::CNT_W'(N)) ? fill_q + 1'b1 : fill_q;
	assign sat = &pos_q;
	assign start = pos_q - xcm_pkg::OFFSET_BITS'(len - 1'b1);

	for (genvar j = 0; j < N; j++) begin : g_cell
		logic [xcm_pkg::SUM_W-1:0] k;
		logic act;
		logic [BW-1:0] din_j;
		logic [BW-1:0] xr_j;
		logic pair_j;

		assign k = xcm_pkg::SUM_W'(j) + xcm_pkg::SUM_W'(len) - xcm_pkg::SUM_W'(N);
		assign act = (xcm_pkg::SUM_W'(j) + xcm_pkg::SUM_W'(len)) >= xcm_pkg::SUM_W'(N);

		if (j == N - 1) begin : g_last
			assign din_j = cipher.cipher_byte;
			assign xr_j = '0;
			assign pair_j = 1'b0;
		end else begin : g_mid
			assign din_j = dout[j+1];
			assign xr_j = xv[j+1];
			assign pair_j = act;
		end

		xcm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.din     (din_j),
			.crib_b  (act ? xcm_pkg::crib_byte(crib_low_q, crib_high_q, k) : '0),
			.active  (pair_j),
			.x_right (xr_j),
			.dout    (dout[j]),
			.x       (xv[j]),
			.agree   (agree[j])
		);
	end

	assign hit = (fill_next >= len) && (&agree);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			if (cipher.stream_end) begin
				fill_q <= '0;
				pos_q <= '0;
			end else begin
				fill_q <= fill_next;
				if (!sat)
					pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && hit) begin
			out_valid_q <= 1'b1;
		end else if (match.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hit) begin
			offset_q <= xcm_pkg::OFFSET_OUT_W'(start);
			key_q <= xv[base[xcm_pkg::IDX_W-1:0]];
			sat_q <= sat;
		end
	end

	assign match.valid = out_valid_q;
	assign match.match_offset = offset_q;
	assign match.found_key = key_q;
	assign match.offset_saturated = sat_q;

endmodule

[sv/xcm_cell.sv]
module xcm_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  xcm_pkg::cell_ctl_t           ctl,
	input  logic [xcm_pkg::BYTE_W-1:0]   din,
	input  logic [xcm_pkg::BYTE_W-1:0]   crib_b,
	input  logic                         active,
	input  logic [xcm_pkg::BYTE_W-1:0]   x_right,
	output logic [xcm_pkg::BYTE_W-1:0]   dout,
	output logic [xcm_pkg::BYTE_W-1:0]   x,
	output logic                         agree
);

	logic [xcm_pkg::BYTE_W-1:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.advance) begin
			byte_q <= ctl.clear ? '0 : din;
		end
	end

	// key candidate for the window that includes the incoming byte
	assign x = din ^ crib_b;
	assign agree = !active || (x == x_right);
	assign dout = byte_q;

endmodule

[sv/xcm_checker.sv]
module xcm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [xcm_pkg::OFFSET_OUT_W-1:0]     out_offset,
	input logic [xcm_pkg::BYTE_W-1:0]           out_key,
	input logic                                 out_sat
);

	// a waiting result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_offset)
			&& $stable(out_key) && $stable(out_sat))
		else $error("result changed while stalled");

	// input side is open whenever the result slot is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with free result slot");

	// a fresh result only follows an accepted beat
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without accepted beat");

	// a new result after a taken one also needs an accepted beat
	a_cause_again: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid || $past(in_valid && in_ready))
		else $error("result repeated");

endmodule

bind xor_crib_match_scanner xcm_checker u_xcm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (cipher.valid),
	.in_ready   (cipher.ready),
	.out_valid  (match.valid),
	.out_ready  (match.ready),
	.out_offset (match.match_offset),
	.out_key    (match.found_key),
	.out_sat    (match.offset_saturated)
);

[test/testbench.sv]
module testbench;

	localparam logic [xcm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 80;
	localparam int ITEM_GOAL = 900;

	typedef struct packed {
		logic [xcm_pkg::BYTE_W-1:0] data;
		logic last;
	} beat_t;

	typedef struct packed {
		logic [xcm_pkg::OFFSET_OUT_W-1:0] offset;
		logic [xcm_pkg::BYTE_W-1:0] key;
		logic sat;
	} hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en;
	logic [xcm_pkg::CFG_IDX_W-1:0] reg_index;
	logic [xcm_pkg::CFG_W-1:0] wr_data;

	xcm_cipher_if cipher();
	xcm_match_if match();

	xor_crib_match_scanner u_top (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.reg_index(reg_index),
		.wr_data(wr_data),
		.cipher(cipher),
		.match(match)
	);

	always #1 clk = ~clk;

	// scanner state as the testbench sees it
	logic [xcm_pkg::LEN_CFG_W-1:0] len_cfg = xcm_pkg::LEN_RESET;
	logic [xcm_pkg::CFG_W-1:0] crib_lo = '0;
	logic [xcm_pkg::CFG_W-1:0] crib_hi = '0;
	logic [xcm_pkg::BYTE_W-1:0] window [xcm_pkg::MAX_CRIB];
	int fill;
	logic [xcm_pkg::OFFSET_BITS-1:0] position;

	hit_t hits_due[$];
	beat_t pending_beats[$];
	int queued = 0;
	int errors = 0;
	int quiet = 0;
	bit calm = 1'b0;
	int stall_asks = 0;
	int stall_seen = 0;
	int hold_left = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h, want %0h", what, got, want);
		errors++;
	endtask

	function automatic int span_len();
		if (len_cfg < 2)
			return 2;
		if (len_cfg > xcm_pkg::MAX_CRIB)
			return xcm_pkg::MAX_CRIB;
		return int'(len_cfg);
	endfunction

	function automatic logic [xcm_pkg::BYTE_W-1:0] plain_at(input int k);
		logic [2*xcm_pkg::CFG_W-1:0] both;
		both = {crib_hi, crib_lo};
		if (k >= xcm_pkg::CRIB_BYTES)
			return '0;
		return both[k*xcm_pkg::BYTE_W +: xcm_pkg::BYTE_W];
	endfunction

	task automatic restart_stream();
		foreach (window[i])
			window[i] = '0;
		fill = 0;
		position = '0;
	endtask

	task automatic scan_byte(input logic [xcm_pkg::BYTE_W-1:0] data, input logic last);
		int n;
		int base;
		int i;
		logic [xcm_pkg::BYTE_W-1:0] key;
		logic [xcm_pkg::OFFSET_BITS-1:0] pos;
		bit sat;
		bit same;
		hit_t hit;
		n = span_len();
		pos = position;
		sat = (pos == '1);
		for (i = 0; i < xcm_pkg::MAX_CRIB - 1; i++)
			window[i] = window[i + 1];
		window[xcm_pkg::MAX_CRIB - 1] = data;
		if (fill < xcm_pkg::MAX_CRIB)
			fill++;
		if (!sat)
			position = pos + 1'b1;
		if (fill >= n) begin
			base = xcm_pkg::MAX_CRIB - n;
			key = window[base] ^ plain_at(0);
			same = 1'b1;
			for (i = 1; i < n; i++)
				if ((window[base + i] ^ plain_at(i)) != key)
					same = 1'b0;
			if (same) begin
				hit.offset = xcm_pkg::OFFSET_OUT_W'(pos - xcm_pkg::OFFSET_BITS'(n - 1));
				hit.key = key;
				hit.sat = sat;
				hits_due.push_back(hit);
			end
		end
		if (last)
			restart_stream();
	endtask

	task automatic push_beat(input logic [xcm_pkg::BYTE_W-1:0] data, input logic last);
		beat_t b;
		b.data = data;
		b.last = last;
		pending_beats.push_back(b);
		queued++;
	endtask

	// crib under a random key, sometimes with one byte spoiled or cut short by stream end
	task automatic queue_cribbed();
		int n;
		int cut;
		int spoil;
		int k;
		logic [xcm_pkg::BYTE_W-1:0] key;
		logic [xcm_pkg::BYTE_W-1:0] flip;
		n = span_len();
		key = xcm_pkg::BYTE_W'($urandom);
		cut = ($urandom_range(99) < 15) ? $urandom_range(1, n - 1) : n;
		spoil = ($urandom_range(99) < 20) ? $urandom_range(n - 1) : -1;
		repeat ($urandom_range(3))
			push_beat(xcm_pkg::BYTE_W'($urandom), 1'b0);
		for (k = 0; k < cut; k++) begin
			flip = (k == spoil) ? xcm_pkg::BYTE_W'(1 << $urandom_range(xcm_pkg::BYTE_W - 1))
				: '0;
			push_beat(plain_at(k) ^ key ^ flip, (cut < n) && (k == cut - 1));
		end
		if (cut == n) begin
			repeat ($urandom_range(2))
				push_beat(xcm_pkg::BYTE_W'($urandom), 1'b0);
			if ($urandom_range(99) < 35)
				push_beat(xcm_pkg::BYTE_W'($urandom), 1'b1);
		end
	endtask

	task automatic queue_noise(input int count);
		repeat (count)
			push_beat(xcm_pkg::BYTE_W'($urandom), $urandom_range(99) < 8);
	endtask

	function automatic logic [xcm_pkg::CFG_W-1:0] wide_random();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic write_reg(input logic [xcm_pkg::CFG_IDX_W-1:0] idx,
			input logic [xcm_pkg::CFG_W-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		reg_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			xcm_pkg::REG_CRIB_LENGTH: len_cfg = data[xcm_pkg::LEN_CFG_W-1:0];
			xcm_pkg::REG_CRIB_LOW: crib_lo = data;
			xcm_pkg::REG_CRIB_HIGH: crib_hi = data;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [xcm_pkg::LEN_CFG_W-1:0] len,
			input logic [xcm_pkg::CFG_W-1:0] lo, input logic [xcm_pkg::CFG_W-1:0] hi);
		logic [xcm_pkg::CFG_W-1:0] junk;
		junk = $urandom_range(1) ? {$urandom, $urandom} : '0;
		// upper bits of the length write carry junk
		write_reg(xcm_pkg::REG_CRIB_LENGTH, {junk[xcm_pkg::CFG_W-1:xcm_pkg::LEN_CFG_W], len});
		write_reg(xcm_pkg::REG_CRIB_LOW, lo);
		write_reg(xcm_pkg::REG_CRIB_HIGH, hi);
		@(negedge clk);
	endtask

	// wait for every beat and match, then for the registered result stage
	task automatic settle();
		while (pending_beats.size() != 0 || cipher.valid || hits_due.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		beat_t nxt;
		if (arst_n && (!cipher.valid || cipher.ready)) begin
			if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
				nxt = pending_beats.pop_front();
				cipher.valid <= 1'b1;
				cipher.cipher_byte <= nxt.data;
				cipher.stream_end <= nxt.last;
			end else begin
				cipher.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_asks != stall_seen) begin
				stall_seen <= stall_asks;
				hold_left <= LONG_HOLD;
				match.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				match.ready <= 1'b0;
			end else begin
				match.ready <= calm || $urandom_range(99) >= 20;
			end
		end
	end

	always @(posedge clk) begin
		hit_t want;
		if (arst_n && match.valid && match.ready) begin
			if (hits_due.size() == 0) begin
				report_mismatch("match with none awaited", 64'(match.match_offset), '0);
			end else begin
				want = hits_due.pop_front();
				if (match.match_offset !== want.offset)
					report_mismatch("match_offset", 64'(match.match_offset),
						64'(want.offset));
				if (match.found_key !== want.key)
					report_mismatch("found_key", 64'(match.found_key), 64'(want.key));
				if (match.offset_saturated !== want.sat)
					report_mismatch("offset_saturated", 64'(match.offset_saturated),
						64'(want.sat));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cipher.valid && cipher.ready)
				scan_byte(cipher.cipher_byte, cipher.stream_end);
			if ((cipher.valid && cipher.ready) || (match.valid && match.ready)) begin
				quiet <= 0;
			end else if (quiet == QUIET_LIMIT) begin
				if (hits_due.size() != 0)
					report_mismatch("matches never arrived", 64'(hits_due.size()), '0);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		int ph;
		int goal;
		int k;
		logic [xcm_pkg::BYTE_W-1:0] key;
		logic [xcm_pkg::LEN_CFG_W-1:0] len;
		wr_en = 1'b0;
		reg_index = '0;
		wr_data = '0;
		cipher.valid = 1'b0;
		cipher.cipher_byte = '0;
		cipher.stream_end = 1'b0;
		match.ready = 1'b0;
		restart_stream();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset config: two-byte crib of zeros
		push_beat(8'h00, 1'b0);
		push_beat(8'h00, 1'b0);
		push_beat(8'hff, 1'b0);
		push_beat(8'hff, 1'b1);
		// a one-byte stream never fills a window
		push_beat(8'h7f, 1'b1);
		settle();

		// full-length crib, match completed by the stream end beat
		write_reg(REG_SPARE, {$urandom, $urandom});
		configure(5'd16, '1, '0);
		key = xcm_pkg::BYTE_W'($urandom);
		for (k = 0; k < xcm_pkg::MAX_CRIB; k++)
			push_beat(plain_at(k) ^ key, k == xcm_pkg::MAX_CRIB - 1);
		settle();

		// length zero acts as two
		configure(5'd0, 64'h0000_0000_0000_c35a, '1);
		push_beat(8'h5a ^ 8'h3c, 1'b0);
		push_beat(8'hc3 ^ 8'h3c, 1'b0);
		push_beat(8'h00, 1'b1);
		settle();

		// every beat after the first matches while the match side holds off
		configure(5'd2, '0, '0);
		calm = 1'b1;
		stall_asks++;
		key = xcm_pkg::BYTE_W'($urandom);
		for (k = 0; k < 60; k++)
			push_beat(key, k == 59);
		settle();
		calm = 1'b0;

		ph = 0;
		while (queued < ITEM_GOAL) begin
			case (ph)
				0: len = 5'd1;
				1: len = 5'd31;
				2: len = 5'd17;
				3: len = 5'd16;
				4: len = 5'd2;
				default: len = ($urandom_range(9) == 0)
					? xcm_pkg::LEN_CFG_W'($urandom_range(31))
					: xcm_pkg::LEN_CFG_W'($urandom_range(2, xcm_pkg::MAX_CRIB));
			endcase
			configure(len, wide_random(), wide_random());
			calm = (ph == 3);
			goal = queued + $urandom_range(60, 90);
			while (queued < goal) begin
				if ($urandom_range(99) < 85)
					queue_cribbed();
				else
					queue_noise($urandom_range(1, 6));
			end
			settle();
			calm = 1'b0;
			ph++;
		end

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[xor_crib_match_scanner.f]
sv/xcm_pkg.sv
sv/xcm_ifs.sv
sv/xcm_cell.sv
sv/xor_crib_match_scanner.sv
sv/xcm_checker.sv
test/testbench.sv
